/* rtl/core/urde_pkg.sv */
package urde_pkg;

   // Command codes carried on the request tuser.
   localparam logic [1:0] FUNC_WRITE   = 2'd0;
   localparam logic [1:0] FUNC_READ    = 2'd1;
   localparam logic [1:0] FUNC_RX_BYTE = 2'd2;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

   // Completion status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
   localparam logic [1:0] STATUS_BAD_CRC  = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

   // Result word kinds.
   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_RESP = 1'b1;

   localparam logic [7:0] SYNC_BYTE = 8'h05;
   localparam logic [7:0] CRC_POLY  = 8'h07;
   localparam logic       READ_FLAG = 1'b1;

   // Response framing: bytes 0 to 7, data in bytes 3 to 6.
   localparam logic [3:0] RX_DATA_FIRST = 4'd3;
   localparam logic [3:0] RX_LAST       = 4'd7;

   // Index of the CRC byte in each outgoing datagram.
   localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
   localparam logic [2:0] READ_LAST_IDX  = 3'd3;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef struct packed {
      logic       fire;
      logic [1:0] status;
      logic [31:0] data;
   } rx_done_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [31:0] read_data;
      logic [1:0]  status;
   } word_type;

   // CRC-8, polynomial 0x07, register shifted MSB first, data bits fed LSB first.
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] b;
      c = crc;
      b = data;
      for (int i = 0; i < 8; i++) begin
         if (c[7] ^ b[0]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
         b = {1'b0, b[7:1]};
      end
      return c;
   endfunction

endpackage

/* rtl/core/urde_rx.sv */
module urde_rx (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic [7:0]            rx_byte,
   output urde_pkg::rx_done_type done,
   output logic                  receiving
);

   logic        receiving_ff, receiving_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic        sync_ff, sync_in;
   logic [31:0] value_ff, value_in;
   logic        at_last;

   assign at_last   = (count_ff >= urde_pkg::RX_LAST);
   assign receiving = receiving_ff;

   // The completion is decided from the state before this word is absorbed.
   always_comb begin
      done.fire   = receiving_ff && ((func == urde_pkg::FUNC_TIMEOUT) ||
                                     ((func == urde_pkg::FUNC_RX_BYTE) && at_last));
      done.status = urde_pkg::STATUS_OK;
      done.data   = '0;
      if (func == urde_pkg::FUNC_TIMEOUT) begin
         done.status = urde_pkg::STATUS_TIMEOUT;
      end else if (!sync_ff) begin
         done.status = urde_pkg::STATUS_BAD_SYNC;
      end else if (crc_ff != rx_byte) begin
         done.status = urde_pkg::STATUS_BAD_CRC;
      end else begin
         done.data = value_ff;
      end
   end

   always_comb begin
      receiving_in = receiving_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      sync_in      = sync_ff;
      value_in     = value_ff;
      if (accept) begin
         if (func == urde_pkg::FUNC_READ) begin
            receiving_in = 1'b1;
            count_in     = '0;
            crc_in       = '0;
            sync_in      = 1'b0;
            value_in     = '0;
         end else if (receiving_ff && (func == urde_pkg::FUNC_TIMEOUT)) begin
            receiving_in = 1'b0;
         end else if (receiving_ff && (func == urde_pkg::FUNC_RX_BYTE)) begin
            count_in = count_ff + 4'd1;
            if (at_last) begin
               receiving_in = 1'b0;
            end else begin
               if (count_ff == '0) begin
                  sync_in = (rx_byte == urde_pkg::SYNC_BYTE);
               end
               if (count_ff >= urde_pkg::RX_DATA_FIRST) begin
                  value_in = {value_ff[23:0], rx_byte};
               end
               crc_in = urde_pkg::crc_feed(crc_ff, rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= '0;
         sync_ff      <= 1'b0;
         value_ff     <= '0;
      end else begin
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         sync_ff      <= sync_in;
         value_ff     <= value_in;
      end
   end

endmodule

/* rtl/core/urde_serializer.sv */
module urde_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic [6:0]            reg_addr,
   input  logic [31:0]           write_data,
   input  urde_pkg::rx_done_type done,
   input  logic [7:0]            node_address,
   input  logic                  out_load,
   output logic                  ready,
   output logic                  emit,
   output logic                  busy,
   output urde_pkg::word_type    word
);

   logic        busy_ff, busy_in;
   logic        resp_ff, resp_in;
   logic        read_ff, read_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  reg_ff, reg_in;
   logic [31:0] data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic        load;
   logic        at_end;
   logic        finish;
   logic [2:0]  last_idx;
   logic [7:0]  cur_byte;

   assign load     = accept && ((func == urde_pkg::FUNC_WRITE) ||
                                (func == urde_pkg::FUNC_READ) || done.fire);
   assign last_idx = read_ff ? urde_pkg::READ_LAST_IDX : urde_pkg::WRITE_LAST_IDX;
   assign at_end   = resp_ff || (idx_ff == last_idx);
   assign emit     = busy_ff && out_load;
   assign finish   = emit && at_end;
   assign ready    = !busy_ff || finish;
   assign busy     = busy_ff;

   always_comb begin
      case (idx_ff)
         3'd0:    cur_byte = urde_pkg::SYNC_BYTE;
         3'd1:    cur_byte = node_address;
         3'd2:    cur_byte = reg_ff;
         3'd3:    cur_byte = data_ff[31:24];
         3'd4:    cur_byte = data_ff[23:16];
         3'd5:    cur_byte = data_ff[15:8];
         3'd6:    cur_byte = data_ff[7:0];
         default: cur_byte = '0;
      endcase
   end

   always_comb begin
      word.kind      = resp_ff ? urde_pkg::KIND_RESP : urde_pkg::KIND_TX;
      word.tx_byte   = '0;
      word.last_byte = 1'b0;
      word.read_data = '0;
      word.status    = urde_pkg::STATUS_OK;
      if (resp_ff) begin
         word.read_data = data_ff;
         word.status    = status_ff;
      end else if (idx_ff == last_idx) begin
         word.tx_byte   = crc_ff;
         word.last_byte = 1'b1;
      end else begin
         word.tx_byte = cur_byte;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      resp_in   = resp_ff;
      read_in   = read_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      reg_in    = reg_ff;
      data_in   = data_ff;
      status_in = status_ff;
      if (finish) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
         crc_in = urde_pkg::crc_feed(crc_ff, cur_byte);
      end
      if (load) begin
         busy_in   = 1'b1;
         resp_in   = !((func == urde_pkg::FUNC_WRITE) || (func == urde_pkg::FUNC_READ));
         read_in   = (func == urde_pkg::FUNC_READ);
         idx_in    = '0;
         crc_in    = '0;
         reg_in    = {(func == urde_pkg::FUNC_READ) & urde_pkg::READ_FLAG, reg_addr};
         data_in   = (func == urde_pkg::FUNC_WRITE) ? write_data : done.data;
         status_in = done.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      resp_ff   <= resp_in;
      read_ff   <= read_in;
      idx_ff    <= idx_in;
      crc_ff    <= crc_in;
      reg_ff    <= reg_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

endmodule

/* rtl/core/uart_register_datagram_engine.sv */
// Register datagram engine for a single-wire serial bus. Each request word carries a command
// in req_tuser: a write (0) produces the eight-byte datagram sync 0x05, node address,
// register with bit 7 clear, four data bytes most significant first and a CRC-8; a read
// request (1) produces the four-byte datagram sync, node address, register with bit 7 set,
// CRC-8, and arms reception; a received byte (2) is collected into the response; a timeout (3)
// aborts a pending response. The CRC-8 uses polynomial 0x07 with initial value 0, shifting MSB
// first and feeding data bits LSB first. Every eighth response byte closes the response and
// yields one completion word (rsp_tuser high) with the data of bytes 3 to 6 and a status of
// ok, bad sync, bad CRC or timeout; data is zero unless the status is ok. Bytes that arrive
// while no response is expected, and timeouts then, produce no word. Throughput: the byte
// serializer sends one result word per cycle while rsp_tready is high, so a write command
// occupies it for its eight bytes, a read request for its four and a response completion for
// its one word, while a received byte that does not complete a response does not occupy it; a new
// request word is taken in the same cycle that the serializer hands its final word to the
// output register. The output register holds one word. While it is full and rsp_tready is
// low the serializer pauses, so every such stall delays the command in progress and holds
// off the next request word. The node address is set through csr_we and csr_wdata and should
// only be changed while the engine is idle.
module uart_register_datagram_engine (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_we,
   input  logic [7:0]                        csr_wdata,     // node_address

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Bits from the lowest up: reg_addr[6:0], write_data[38:7], rx_byte[46:39], zero fill.
   input  logic [urde_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [1:0]                        req_tuser,     // func

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Bits from the lowest up: tx_byte[7:0], read_data[39:8], status[41:40], zero fill.
   output logic [urde_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,     // last_byte
   output logic                              rsp_tuser      // kind
);

   logic                  accept;
   logic [1:0]            func;
   logic [6:0]            reg_addr;
   logic [31:0]           write_data;
   logic [7:0]            rx_byte;
   logic [7:0]            node_address_ff;
   logic                  out_load;
   logic                  emit;
   logic                  ser_busy;
   logic                  receiving;
   urde_pkg::rx_done_type rx_done;
   urde_pkg::word_type    ser_word;
   logic                  out_valid_ff, out_valid_in;
   urde_pkg::word_type    out_word_ff;

   assign func       = req_tuser;
   assign reg_addr   = req_tdata[6:0];
   assign write_data = req_tdata[38:7];
   assign rx_byte    = req_tdata[46:39];
   assign accept     = req_tvalid && req_tready;

   // The node address register; the user writes it only while the engine is idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= '0;
      end else if (csr_we) begin
         node_address_ff <= csr_wdata;
      end
   end

   // Response collection: sync check, running CRC and data assembly, one byte per word.
   urde_rx u_rx (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (func),
      .rx_byte   (rx_byte),
      .done      (rx_done),
      .receiving (receiving)
   );

   // Holds the accepted command and sends its words one per cycle unless stalled, CRC computed on the fly.
   urde_serializer u_ser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (func),
      .reg_addr     (reg_addr),
      .write_data   (write_data),
      .done         (rx_done),
      .node_address (node_address_ff),
      .out_load     (out_load),
      .ready        (req_tready),
      .emit         (emit),
      .busy         (ser_busy),
      .word         (ser_word)
   );

   // Output register: it takes a new word whenever it is empty or its word leaves now.
   assign out_load = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_word_ff <= ser_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_word_ff.kind;
   assign rsp_tlast  = out_word_ff.last_byte;
   assign rsp_tdata  = {6'd0, out_word_ff.status, out_word_ff.read_data, out_word_ff.tx_byte};

   // A write or read command always leaves the serializer with words to send.
   assert property (@(posedge clock) disable iff (reset)
      accept && ((func == urde_pkg::FUNC_WRITE) || (func == urde_pkg::FUNC_READ)) |=> ser_busy)
      else $error("serializer idle after a transmit command");

   // A read request always leaves the engine waiting for a response.
   assert property (@(posedge clock) disable iff (reset)
      accept && (func == urde_pkg::FUNC_READ) |=> receiving)
      else $error("reception not armed after a read request");

   // A failed completion never carries data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == urde_pkg::KIND_RESP) &&
      (rsp_tdata[41:40] != urde_pkg::STATUS_OK) |-> (rsp_tdata[39:8] == '0))
      else $error("data on a failed completion");

   // A transmit word carries neither data nor status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == urde_pkg::KIND_TX) |->
      (rsp_tdata[41:8] == '0))
      else $error("stray fields on a transmit word");

endmodule

/* sim/uart_register_datagram_engine_tb.sv */
module uart_register_datagram_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Testbench for the single-wire register datagram engine.
   //
   // Each request word carries a command in req_tuser. A write produces an eight-byte datagram.
   // A read request produces a four-byte datagram and arms reception of an eight-byte reply.
   // Received bytes and timeouts complete or abort that reply. A predictor inside this module
   // follows the same rules as the engine and queues the bus words that each accepted request
   // should produce. The response side takes the words off that queue and compares them field
   // by field. Both handshake sides idle at random.

   // The run is declared hung after this many cycles in which no word moves on any port.
   localparam int IDLE_LIMIT    = 2000;
   // A received byte that completes nothing produces no word to wait for, so the settle
   // cycles below separate the last expected word from a node address change.
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 30;
   localparam int MAX_PRINTED   = 40;

   // One predicted result word, in the order of the response fields.
   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [31:0] read_data;
      logic [1:0]  status;
   } bus_word_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_we     = 1'b0;
   logic [7:0]                       csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [urde_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]                       req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [urde_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;

   // The predictor's copy of the node address and of the reply reception state.
   logic [7:0]  node_addr_m   = '0;
   bit          reply_armed   = 1'b0;
   logic [3:0]  reply_count   = '0;
   logic [7:0]  reply_crc     = '0;
   bit          reply_sync_ok = 1'b0;
   logic [31:0] reply_value   = '0;

   // Words that the engine still owes us, oldest first.
   bus_word_type bus_words_q[$];

   int  mismatch_count = 0;
   int  active_items   = 0;   // accepted requests that the engine acted on
   int  quiet_cycles   = 0;
   bit  tx_fast        = 1'b0;

   int  stall_left  = 0;
   int  ready_mode  = 0;
   int  mode_left   = 0;

   uart_register_datagram_engine dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // CRC-8 with polynomial 0x07 and the register shifted MSB first, while the data bits
   // enter LSB first.
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc;
      for (int i = 0; i < 8; i++)
         acc = {acc[6:0], 1'b0} ^ ((acc[7] ^ data[i]) ? urde_pkg::CRC_POLY : 8'h00);
      return acc;
   endfunction

   function automatic bus_word_type make_word(input logic k, input logic [7:0] tx,
                                              input logic l, input logic [31:0] d,
                                              input logic [1:0] s);
      return {k, tx, l, d, s};
   endfunction

   // Queues the first n-1 bytes of a datagram, packed with byte 0 lowest, followed by
   // their CRC as the last byte.
   function automatic void queue_datagram(input logic [63:0] bytes, input int n);
      logic [7:0] crc;
      crc = 8'h00;
      for (int i = 0; i < n - 1; i++) begin
         crc = crc8_fold(crc, bytes[8*i +: 8]);
         bus_words_q.push_back(make_word(urde_pkg::KIND_TX, bytes[8*i +: 8], 1'b0, '0,
                                         urde_pkg::STATUS_OK));
      end
      bus_words_q.push_back(make_word(urde_pkg::KIND_TX, crc, 1'b1, '0, urde_pkg::STATUS_OK));
   endfunction

   // Advances the predicted engine by one accepted request and queues the words that
   // the request causes. Returns 0 when the engine ignores the request.
   function automatic bit engine_step(input logic [1:0] fn, input logic [6:0] ra,
                                      input logic [31:0] wd, input logic [7:0] rb);
      case (fn)
         urde_pkg::FUNC_WRITE: begin
            queue_datagram({8'h00, wd[7:0], wd[15:8], wd[23:16], wd[31:24],
                            1'b0, ra, node_addr_m, urde_pkg::SYNC_BYTE}, 8);
            return 1'b1;
         end
         urde_pkg::FUNC_READ: begin
            queue_datagram({32'h0, 8'h00, urde_pkg::READ_FLAG, ra, node_addr_m,
                            urde_pkg::SYNC_BYTE}, 4);
            reply_armed   = 1'b1;
            reply_count   = '0;
            reply_crc     = '0;
            reply_sync_ok = 1'b0;
            reply_value   = '0;
            return 1'b1;
         end
         urde_pkg::FUNC_TIMEOUT: begin
            if (!reply_armed)
               return 1'b0;
            reply_armed = 1'b0;
            bus_words_q.push_back(make_word(urde_pkg::KIND_RESP, 8'h00, 1'b0, '0,
                                            urde_pkg::STATUS_TIMEOUT));
            return 1'b1;
         end
         default: begin
            if (!reply_armed)
               return 1'b0;
            if (reply_count < urde_pkg::RX_LAST) begin
               if (reply_count == 4'd0)
                  reply_sync_ok = (rb == urde_pkg::SYNC_BYTE);
               if (reply_count >= urde_pkg::RX_DATA_FIRST)
                  reply_value = {reply_value[23:0], rb};
               reply_crc   = crc8_fold(reply_crc, rb);
               reply_count = reply_count + 4'd1;
               return 1'b1;
            end
            // The eighth byte carries the CRC and closes the reply. A bad sync byte takes
            // precedence over a bad CRC.
            reply_count = reply_count + 4'd1;
            reply_armed = 1'b0;
            if (!reply_sync_ok)
               bus_words_q.push_back(make_word(urde_pkg::KIND_RESP, 8'h00, 1'b0, '0,
                                               urde_pkg::STATUS_BAD_SYNC));
            else if (reply_crc != rb)
               bus_words_q.push_back(make_word(urde_pkg::KIND_RESP, 8'h00, 1'b0, '0,
                                               urde_pkg::STATUS_BAD_CRC));
            else
               bus_words_q.push_back(make_word(urde_pkg::KIND_RESP, 8'h00, 1'b0, reply_value,
                                               urde_pkg::STATUS_OK));
            return 1'b1;
         end
      endcase
   endfunction

   // Builds a well-formed reply frame, packed with byte 0 lowest and a valid CRC in byte 7.
   function automatic logic [63:0] reply_frame(input logic [7:0] from_addr,
                                               input logic [7:0] reg_byte,
                                               input logic [31:0] value);
      logic [63:0] frame;
      logic [7:0]  crc;
      frame = {8'h00, value[7:0], value[15:8], value[23:16], value[31:24],
               reg_byte, from_addr, urde_pkg::SYNC_BYTE};
      crc = 8'h00;
      for (int i = 0; i < 7; i++)
         crc = crc8_fold(crc, frame[8*i +: 8]);
      frame[63:56] = crc;
      return frame;
   endfunction

   // Most gaps are zero or short. Now and then a gap is long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Offers one request word after an optional gap and holds it until the engine takes it.
   // On acceptance the valid is left high, so a following word can go out back to back.
   task automatic send_word(input logic [1:0] fn, input logic [6:0] ra,
                            input logic [31:0] wd, input logic [7:0] rb);
      int gap;
      gap = tx_fast ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {1'b0, rb, wd, ra};
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      if (engine_step(fn, ra, wd, rb))
         active_items++;
   endtask

   // Feeds the first n bytes of a reply frame. The fields that the engine does not use
   // for a received byte carry random values.
   task automatic send_reply(input logic [63:0] frame, input int n);
      for (int i = 0; i < n; i++)
         send_word(urde_pkg::FUNC_RX_BYTE, 7'($urandom), $urandom, frame[8*i +: 8]);
   endtask

   // Stops sending and waits until every predicted word has arrived and the engine has
   // had time to finish any byte that causes no word.
   task automatic drain_engine();
      req_tvalid <= 1'b0;
      while (bus_words_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_address(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      node_addr_m = value;
      csr_we    <= 1'b0;
   endtask

   // A received byte and a timeout that arrive while no reply is armed must produce nothing.
   task automatic test_idle_inputs();
      send_word(urde_pkg::FUNC_RX_BYTE, 7'($urandom), $urandom, urde_pkg::SYNC_BYTE);
      send_word(urde_pkg::FUNC_TIMEOUT, 7'($urandom), $urandom, 8'($urandom));
   endtask

   // Write datagrams at both ends of the register and data ranges, first with the node
   // address as it comes out of reset and then with the highest address.
   task automatic test_write_extremes();
      send_word(urde_pkg::FUNC_WRITE, 7'h00, 32'h0000_0000, 8'($urandom));
      drain_engine();
      write_node_address(8'hFF);
      send_word(urde_pkg::FUNC_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'($urandom));
   endtask

   // A complete and correct reply, followed by a stray byte that must be ignored because
   // reception has ended.
   task automatic test_read_good_reply();
      send_word(urde_pkg::FUNC_READ, 7'h7F, $urandom, 8'($urandom));
      send_reply(reply_frame(8'hFF, 8'h7F, 32'h8000_0001), 8);
      send_word(urde_pkg::FUNC_RX_BYTE, 7'($urandom), $urandom, 8'hFF);
   endtask

   // A second read request throws away a partial reply. A timeout then ends reception.
   task automatic test_read_timeout();
      send_word(urde_pkg::FUNC_READ, 7'h00, $urandom, 8'($urandom));
      send_word(urde_pkg::FUNC_RX_BYTE, 7'($urandom), $urandom, urde_pkg::SYNC_BYTE);
      send_word(urde_pkg::FUNC_READ, 7'h55, $urandom, 8'($urandom));
      send_word(urde_pkg::FUNC_RX_BYTE, 7'($urandom), $urandom, urde_pkg::SYNC_BYTE);
      send_word(urde_pkg::FUNC_TIMEOUT, 7'($urandom), $urandom, 8'($urandom));
   endtask

   // The reply has both a wrong sync byte and a wrong CRC. It must be reported as bad sync.
   task automatic test_sync_before_crc();
      logic [63:0] frame;
      frame = reply_frame(8'hFF, 8'h2A, 32'hDEAD_BEEF);
      frame[7:0]   = 8'h00;
      frame[63:56] = ~frame[63:56];
      send_word(urde_pkg::FUNC_READ, 7'h2A, $urandom, 8'($urandom));
      send_reply(frame, 8);
   endtask

   // One read request and a reply that is often good. Sometimes the reply has a damaged sync,
   // CRC or middle byte, or it is cut short and then either times out or is abandoned.
   task automatic random_read_transaction();
      logic [63:0] frame;
      logic [6:0]  ra;
      int          flavor;
      int          flip;
      ra = 7'($urandom);
      send_word(urde_pkg::FUNC_READ, ra, $urandom, 8'($urandom));
      frame  = reply_frame(8'($urandom), {1'b1, ra}, $urandom);
      flavor = $urandom_range(0, 99);
      if (flavor < 15) begin
         frame[7:0] = 8'($urandom);
         if (frame[7:0] == urde_pkg::SYNC_BYTE)
            frame[7:0] = ~urde_pkg::SYNC_BYTE;
      end else if (flavor < 30) begin
         frame[63:56] = frame[63:56] ^ (8'h01 << $urandom_range(0, 7));
      end else if (flavor < 35) begin
         flip        = $urandom_range(8, 55);
         frame[flip] = ~frame[flip];
      end
      if (flavor >= 80 && flavor < 90) begin
         send_reply(frame, $urandom_range(0, 7));
         send_word(urde_pkg::FUNC_TIMEOUT, 7'($urandom), $urandom, 8'($urandom));
      end else if (flavor >= 90) begin
         send_reply(frame, $urandom_range(1, 7));
      end else begin
         send_reply(frame, 8);
         if ($urandom_range(0, 3) == 0)
            send_word(urde_pkg::FUNC_RX_BYTE, 7'($urandom), $urandom, 8'($urandom));
      end
   endtask

   // Four phases, each under its own node address. Each phase starts only after the
   // engine has delivered every word that it owes. In the second phase the sender never
   // idles.
   task automatic test_random_traffic();
      int target;
      int pick;
      for (int phase = 0; phase < 4; phase++) begin
         drain_engine();
         case (phase)
            0:       write_node_address(8'h00);
            2:       write_node_address(8'hFF);
            default: write_node_address(8'($urandom));
         endcase
         tx_fast = (phase == 1);
         target  = active_items + PHASE_ITEMS;
         while (active_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               send_word(urde_pkg::FUNC_WRITE, 7'($urandom), $urandom, 8'($urandom));
            else if (pick < 75)
               random_read_transaction();
            else
               send_word(2'($urandom_range(0, 3)), 7'($urandom), $urandom, 8'($urandom));
         end
      end
      tx_fast = 1'b0;
   endtask

   // The response side stalls at random. It switches now and then between running with
   // no stalls and two stall densities.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (ready_mode != 0 && $urandom_range(0, 99) < ready_mode * 20)
            stall_left = idle_length();
      end
   end

   // Every accepted response word is compared with the oldest prediction.
   always @(posedge clock) begin : word_check
      bus_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (bus_words_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = bus_words_q.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch($sformatf("kind %b, expected %b", rsp_tuser, want.kind));
            if (rsp_tdata[7:0] !== want.tx_byte)
               report_mismatch($sformatf("tx_byte %h, expected %h",
                                         rsp_tdata[7:0], want.tx_byte));
            if (rsp_tlast !== want.last_byte)
               report_mismatch($sformatf("last_byte %b, expected %b",
                                         rsp_tlast, want.last_byte));
            if (rsp_tdata[39:8] !== want.read_data)
               report_mismatch($sformatf("read_data %h, expected %h",
                                         rsp_tdata[39:8], want.read_data));
            if (rsp_tdata[41:40] !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tdata[41:40], want.status));
         end
      end
   end

   // Watchdog: ends the run if no word moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_inputs();
      test_write_extremes();
      test_read_good_reply();
      test_read_timeout();
      test_sync_before_crc();
      test_random_traffic();
      drain_engine();
      if (mismatch_count == 0 && bus_words_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
